/* rtl/afc_pkg.sv */
// Shared types and constants for the frustum culling block.
// Used by every module under aabb_frustum_cull except afc_fifo; depends on nothing.
`default_nettype none

package afc_pkg;

	localparam int VAL_W           = 32;  // Q16.16 operand width
	localparam int TOL_W           = 16;
	localparam int COEFS_PER_PLANE = 4;
	localparam int NUM_PLANES_DEF  = 4;
	localparam int MID_DEPTH_DEF   = 4;   // front to back queue
	localparam int OUT_DEPTH_DEF   = 8;   // result queue, covers back pipeline latency

	// coefficient slots within one plane
	localparam logic [1:0] CI_NX = 2'd0;
	localparam logic [1:0] CI_NY = 2'd1;
	localparam logic [1:0] CI_NZ = 2'd2;
	localparam logic [1:0] CI_D  = 2'd3;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TEST = 1'b1
	} opcode_t;

	// request as taken from the ports
	typedef struct packed {
		opcode_t                  opcode;
		logic [1:0]               plane_index;
		logic [1:0]               coeff_index;
		logic signed [VAL_W-1:0]  coeff_value;
		logic signed [VAL_W-1:0]  box_x_min;
		logic signed [VAL_W-1:0]  box_x_max;
		logic signed [VAL_W-1:0]  box_y_min;
		logic signed [VAL_W-1:0]  box_y_max;
		logic signed [VAL_W-1:0]  box_z_min;
		logic signed [VAL_W-1:0]  box_z_max;
	} in_item_t;

	// classified request, bounds already ordered per axis
	typedef struct packed {
		logic                     is_test;
		logic [1:0]               plane_index;
		logic [1:0]               coeff_index;
		logic signed [VAL_W-1:0]  coeff_value;
		logic signed [VAL_W-1:0]  x_lo;
		logic signed [VAL_W-1:0]  x_hi;
		logic signed [VAL_W-1:0]  y_lo;
		logic signed [VAL_W-1:0]  y_hi;
		logic signed [VAL_W-1:0]  z_lo;
		logic signed [VAL_W-1:0]  z_hi;
	} mid_item_t;

endpackage

`default_nettype wire

/* rtl/afc_fifo.sv */
// Small register queue with full/empty flags, used between front and back
// and for results. Depends on nothing but its parameters.
`default_nettype none

module afc_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (!full || rd_en))
		else $error("afc_fifo: write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty)
		else $error("afc_fifo: read while empty");
`endif

endmodule

`default_nettype wire

/* rtl/afc_front.sv */
// Front end: takes requests, drops loads to planes that do not exist,
// orders the box bounds per axis. Depends on afc_pkg.
`default_nettype none

module afc_front #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire afc_pkg::in_item_t in_item,
	input  wire logic              in_push,
	output logic                   in_full,
	output afc_pkg::mid_item_t     mid_item,
	output logic                   mid_push,
	input  wire logic              mid_full
);

	afc_pkg::in_item_t item_s1;
	logic              valid_s1;
	logic              is_test;
	logic              drop;
	logic              advance;
	logic              accept;

	assign is_test = (item_s1.opcode == afc_pkg::OP_TEST);
	// loads beyond the plane store are discarded here
	assign drop    = valid_s1 && !is_test && !(int'(item_s1.plane_index) < NUM_PLANES);
	assign advance = !valid_s1 || drop || !mid_full;
	assign in_full = !advance;
	assign accept  = in_push && advance;
	assign mid_push = valid_s1 && !drop && !mid_full;

	always_comb begin
		mid_item.is_test     = is_test;
		mid_item.plane_index = item_s1.plane_index;
		mid_item.coeff_index = item_s1.coeff_index;
		mid_item.coeff_value = item_s1.coeff_value;
		mid_item.x_lo = (item_s1.box_x_min < item_s1.box_x_max) ? item_s1.box_x_min
			: item_s1.box_x_max;
		mid_item.x_hi = (item_s1.box_x_min < item_s1.box_x_max) ? item_s1.box_x_max
			: item_s1.box_x_min;
		mid_item.y_lo = (item_s1.box_y_min < item_s1.box_y_max) ? item_s1.box_y_min
			: item_s1.box_y_max;
		mid_item.y_hi = (item_s1.box_y_min < item_s1.box_y_max) ? item_s1.box_y_max
			: item_s1.box_y_min;
		mid_item.z_lo = (item_s1.box_z_min < item_s1.box_z_max) ? item_s1.box_z_min
			: item_s1.box_z_max;
		mid_item.z_hi = (item_s1.box_z_min < item_s1.box_z_max) ? item_s1.box_z_max
			: item_s1.box_z_min;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
		end
	end

endmodule

`default_nettype wire

/* rtl/afc_back.sv */
// Back end: plane store, per-plane worst corner distance and cull decision.
// Depends on afc_pkg; feeds the result queue under a credit count.
`default_nettype none

module afc_back #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF,
	parameter int OUT_DEPTH  = afc_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire afc_pkg::mid_item_t         head,
	input  wire logic                       head_valid,
	output logic                            head_pop,
	input  wire logic [afc_pkg::TOL_W-1:0]  tolerance,
	input  wire logic                       out_pop,
	output logic                            res_valid,
	output logic                            res_visible
);

	localparam int CNT_W = $clog2(OUT_DEPTH + 1);
	localparam int VW    = afc_pkg::VAL_W;
	localparam int PW    = 2 * VW;          // exact product
	localparam int DW    = VW + 18;         // offset and slack, Q32.32 aligned
	localparam int SW    = PW + 1;          // two-term sum
	localparam int TW    = PW + 2;          // full sum

	logic signed [VW-1:0] store_q [NUM_PLANES][afc_pkg::COEFS_PER_PLANE];

	logic signed [PW-1:0] prod_c  [NUM_PLANES][3];
	logic signed [DW-1:0] dt_c    [NUM_PLANES];
	logic signed [PW-1:0] prod_s1 [NUM_PLANES][3];
	logic signed [DW-1:0] dt_s1   [NUM_PLANES];
	logic signed [SW-1:0] sxy_s2  [NUM_PLANES];
	logic signed [SW-1:0] sz_s2   [NUM_PLANES];
	logic signed [TW-1:0] dist_c  [NUM_PLANES];
	logic signed [VW-1:0] lo      [3];
	logic signed [VW-1:0] hi      [3];
	logic [NUM_PLANES-1:0] out_c;
	logic                 cull_s3;
	logic                 valid_s1, valid_s2, valid_s3;
	logic [CNT_W-1:0]     credit_q;
	logic                 has_credit;
	logic                 take_test;
	logic                 take_load;

	assign has_credit = (credit_q < CNT_W'(OUT_DEPTH));
	assign head_pop   = head_valid && (!head.is_test || has_credit);
	assign take_test  = head_pop && head.is_test;
	assign take_load  = head_pop && !head.is_test;

	assign lo[0] = head.x_lo;
	assign hi[0] = head.x_hi;
	assign lo[1] = head.y_lo;
	assign hi[1] = head.y_hi;
	assign lo[2] = head.z_lo;
	assign hi[2] = head.z_hi;

	// worst corner per plane: a negative normal component takes the lower bound
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			for (int a = 0; a < 3; a++) begin
				prod_c[p][a] = store_q[p][a] * (store_q[p][a][VW-1] ? lo[a] : hi[a]);
			end
			dt_c[p] = $signed({{2{store_q[p][afc_pkg::CI_D][VW-1]}},
				store_q[p][afc_pkg::CI_D], 16'b0})
				+ $signed({{(DW - afc_pkg::TOL_W - 16){1'b0}}, tolerance, 16'b0});
		end
	end

	// plane culls when even its worst corner lies below minus the slack
	always_comb begin
		for (int p = 0; p < NUM_PLANES; p++) begin
			dist_c[p] = TW'(sxy_s2[p]) + TW'(sz_s2[p]);
			out_c[p]  = dist_c[p][TW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				for (int c = 0; c < afc_pkg::COEFS_PER_PLANE; c++) begin
					store_q[p][c] <= '0;
				end
			end
		end else if (take_load) begin
			for (int p = 0; p < NUM_PLANES; p++) begin
				if (int'(head.plane_index) == p) begin
					store_q[p][head.coeff_index] <= head.coeff_value;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod_c;
		dt_s1   <= dt_c;
		for (int p = 0; p < NUM_PLANES; p++) begin
			sxy_s2[p] <= SW'(prod_s1[p][0]) + SW'(prod_s1[p][1]);
			sz_s2[p]  <= SW'(prod_s1[p][2]) + SW'(dt_s1[p]);
		end
		cull_s3 <= |out_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			credit_q <= '0;
		end else begin
			valid_s1 <= take_test;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			unique case ({take_test, out_pop})
				2'b10:   credit_q <= credit_q + 1'b1;
				2'b01:   credit_q <= credit_q - 1'b1;
				default: credit_q <= credit_q;
			endcase
		end
	end

	assign res_valid   = valid_s3;
	assign res_visible = !cull_s3;

`ifndef SYNTHESIS
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		credit_q <= CNT_W'(OUT_DEPTH))
		else $error("afc_back: credit count beyond result queue depth");
	a_inflight_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 || valid_s2 || valid_s3) |-> (credit_q != '0))
		else $error("afc_back: test in flight without a credit");
`endif

endmodule

`default_nettype wire

/* rtl/aabb_frustum_cull.sv */
// Frustum culling of axis-aligned boxes: top level joining front end,
// front/back queue, back end and result queue. Depends on afc_pkg, afc_front, afc_fifo and afc_back.
//
//  channel      direction  handshake              payload
//  request      in         push / full            opcode, plane_index, coeff_index,
//                                                 coeff_value, box_* bounds
//  result       out        empty / pop            visible
//  tolerance    in         tolerance_we           tolerance_data
//
// One request per cycle sustained while the result side keeps popping; a test's result
// passes the front register, queue and three back stages, a load gives none.
// Rate is set by the back pipeline: three 32x32 products per plane per cycle.
// The result queue holds eight entries; a stalled pop backs up into the
// front/back queue and then raises full. Reset clears the plane store,
// tolerance and all queues at once.
`default_nettype none

module aabb_frustum_cull #(
	parameter int NUM_PLANES = afc_pkg::NUM_PLANES_DEF,
	parameter int MID_DEPTH  = afc_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH  = afc_pkg::OUT_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	output logic                            full,
	input  wire logic                       opcode,
	input  wire logic [1:0]                 plane_index,
	input  wire logic [1:0]                 coeff_index,
	input  wire logic signed [31:0]         coeff_value,
	input  wire logic signed [31:0]         box_x_min,
	input  wire logic signed [31:0]         box_x_max,
	input  wire logic signed [31:0]         box_y_min,
	input  wire logic signed [31:0]         box_y_max,
	input  wire logic signed [31:0]         box_z_min,
	input  wire logic signed [31:0]         box_z_max,
	output logic                            empty,
	input  wire logic                       pop,
	output logic                            visible,
	input  wire logic                       tolerance_we,
	input  wire logic [afc_pkg::TOL_W-1:0]  tolerance_data
);

	localparam int MID_W = $bits(afc_pkg::mid_item_t);

	afc_pkg::in_item_t  in_item;
	afc_pkg::mid_item_t mid_in;
	afc_pkg::mid_item_t mid_head;
	logic               mid_push;
	logic               mid_full;
	logic               mid_empty;
	logic               mid_pop;
	logic [afc_pkg::TOL_W-1:0] tolerance_q;
	logic               res_valid;
	logic               res_visible;
	logic               out_pop;
	logic               out_full;

	always_comb begin
		in_item.opcode      = afc_pkg::opcode_t'(opcode);
		in_item.plane_index = plane_index;
		in_item.coeff_index = coeff_index;
		in_item.coeff_value = coeff_value;
		in_item.box_x_min   = box_x_min;
		in_item.box_x_max   = box_x_max;
		in_item.box_y_min   = box_y_min;
		in_item.box_y_max   = box_y_max;
		in_item.box_z_min   = box_z_min;
		in_item.box_z_max   = box_z_max;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= '0;
		end else if (tolerance_we) begin
			tolerance_q <= tolerance_data;
		end
	end

	afc_front #(
		.NUM_PLANES (NUM_PLANES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.in_push  (push),
		.in_full  (full),
		.mid_item (mid_in),
		.mid_push (mid_push),
		.mid_full (mid_full)
	);

	afc_fifo #(
		.WIDTH (MID_W),
		.DEPTH (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_in),
		.rd_en   (mid_pop),
		.rd_data (mid_head),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	afc_back #(
		.NUM_PLANES (NUM_PLANES),
		.OUT_DEPTH  (OUT_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (mid_head),
		.head_valid  (!mid_empty),
		.head_pop    (mid_pop),
		.tolerance   (tolerance_q),
		.out_pop     (out_pop),
		.res_valid   (res_valid),
		.res_visible (res_visible)
	);

	assign out_pop = pop && !empty;

	afc_fifo #(
		.WIDTH (1),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res_visible),
		.rd_en   (out_pop),
		.rd_data (visible),
		.full    (out_full),
		.empty   (empty)
	);

`ifndef SYNTHESIS
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !out_full)
		else $error("aabb_frustum_cull: result arrives with result queue full");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_aabb_frustum_cull.sv */
// Testbench for aabb_frustum_cull: plane loads and box tests pushed through the
// request queue, visibility results popped and checked against a local predictor.
// Depends on afc_pkg and the RTL of aabb_frustum_cull.
module tb_aabb_frustum_cull;

	localparam logic [1:0] PL_LEFT   = 2'd0;
	localparam logic [1:0] PL_RIGHT  = 2'd1;
	localparam logic [1:0] PL_TOP    = 2'd2;
	localparam logic [1:0] PL_BOTTOM = 2'd3;

	localparam int N_PLANES      = afc_pkg::NUM_PLANES_DEF;
	localparam int N_COEFS       = afc_pkg::COEFS_PER_PLANE;
	localparam int SETTLE_CYCLES = 24;
	localparam int HOLD_CYCLES   = 120;
	localparam int IDLE_LIMIT    = 2000;
	localparam int N_PHASES      = 5;
	localparam int PHASE_ITEMS   = 100;

	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] VMIN = 32'sh8000_0000;
	localparam logic signed [31:0] VMAX = 32'sh7fff_ffff;

	typedef struct {
		afc_pkg::in_item_t req;
		bit                known;
		bit                vis;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic push, full, empty, pop;
	logic opcode;
	logic [1:0] plane_index, coeff_index;
	logic signed [31:0] coeff_value;
	logic signed [31:0] box_x_min, box_x_max, box_y_min, box_y_max, box_z_min, box_z_max;
	logic visible;
	logic tolerance_we;
	logic [afc_pkg::TOL_W-1:0] tolerance_data;

	// predictor state
	logic signed [31:0]        plane_mem [N_PLANES*N_COEFS];
	logic [afc_pkg::TOL_W-1:0] tol_model;
	bit                        visible_due [$];

	int n_err;
	int idle_cycles;
	int tx_max_gap, rx_max_gap;
	bit hold_rx;

	always #5 clk = ~clk;

	aabb_frustum_cull dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.opcode         (opcode),
		.plane_index    (plane_index),
		.coeff_index    (coeff_index),
		.coeff_value    (coeff_value),
		.box_x_min      (box_x_min),
		.box_x_max      (box_x_max),
		.box_y_min      (box_y_min),
		.box_y_max      (box_y_max),
		.box_z_min      (box_z_min),
		.box_z_max      (box_z_max),
		.empty          (empty),
		.pop            (pop),
		.visible        (visible),
		.tolerance_we   (tolerance_we),
		.tolerance_data (tolerance_data)
	);

	function automatic void store_coeff(afc_pkg::in_item_t r);
		if (int'(r.plane_index) < N_PLANES)
			plane_mem[int'(r.plane_index)*N_COEFS + int'(r.coeff_index)] =
				r.coeff_value;
	endfunction

	// culled only when one plane has all eight corners below -tolerance
	function automatic bit box_visible(afc_pkg::in_item_t r);
		logic signed [31:0] xs [2];
		logic signed [31:0] ys [2];
		logic signed [31:0] zs [2];
		logic signed [71:0] sdist;
		int b;
		int n_out;
		xs[0] = r.box_x_min;
		xs[1] = r.box_x_max;
		ys[0] = r.box_y_min;
		ys[1] = r.box_y_max;
		zs[0] = r.box_z_min;
		zs[1] = r.box_z_max;
		for (int p = 0; p < N_PLANES; p++) begin
			b = p*N_COEFS;
			n_out = 0;
			for (int k = 0; k < 8; k++) begin
				sdist = plane_mem[b+afc_pkg::CI_NX]*xs[k & 1]
					+ plane_mem[b+afc_pkg::CI_NY]*ys[(k >> 1) & 1]
					+ plane_mem[b+afc_pkg::CI_NZ]*zs[(k >> 2) & 1]
					+ plane_mem[b+afc_pkg::CI_D]*65536
					+ $signed({1'b0, tol_model})*65536;
				if (sdist < 0)
					n_out++;
			end
			if (n_out == 8)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic afc_pkg::in_item_t mk_load(logic [1:0] pl, logic [1:0] ci,
			logic signed [31:0] v);
		afc_pkg::in_item_t r;
		r.opcode      = afc_pkg::OP_LOAD;
		r.plane_index = pl;
		r.coeff_index = ci;
		r.coeff_value = v;
		r.box_x_min   = $urandom;
		r.box_x_max   = $urandom;
		r.box_y_min   = $urandom;
		r.box_y_max   = $urandom;
		r.box_z_min   = $urandom;
		r.box_z_max   = $urandom;
		return r;
	endfunction

	function automatic afc_pkg::in_item_t mk_test(logic signed [31:0] xl,
			logic signed [31:0] xh,
			logic signed [31:0] yl, logic signed [31:0] yh,
			logic signed [31:0] zl, logic signed [31:0] zh);
		afc_pkg::in_item_t r;
		r.opcode      = afc_pkg::OP_TEST;
		r.plane_index = 2'($urandom_range(0, 3));
		r.coeff_index = 2'($urandom_range(0, 3));
		r.coeff_value = $urandom;
		r.box_x_min   = xl;
		r.box_x_max   = xh;
		r.box_y_min   = yl;
		r.box_y_max   = yh;
		r.box_z_min   = zl;
		r.box_z_max   = zh;
		return r;
	endfunction

	// box span of up to +-20.0 around a centre within +-60.0, now and then swapped
	function automatic void rand_span(output logic signed [31:0] lo,
			output logic signed [31:0] hi);
		int c;
		int h;
		c  = int'($urandom_range(0, 7864320)) - 3932160;
		h  = int'($urandom_range(0, 1310720));
		lo = c - h;
		hi = c + h;
		if ($urandom_range(0, 9) == 0) begin
			lo = c + h;
			hi = c - h;
		end
	endfunction

	function automatic afc_pkg::in_item_t rand_req();
		afc_pkg::in_item_t r;
		int unsigned pick;
		r = mk_test($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		r.opcode = afc_pkg::opcode_t'($urandom_range(0, 1));
		pick = $urandom_range(0, 99);
		if (pick < 12)
			return r;
		if (pick < 35) begin
			r.opcode = afc_pkg::OP_LOAD;
			// normals within +-2.0, offsets within +-50.0
			if (r.coeff_index == afc_pkg::CI_D)
				r.coeff_value = int'($urandom_range(0, 6553600)) - 3276800;
			else
				r.coeff_value = int'($urandom_range(0, 262144)) - 131072;
			return r;
		end
		r.opcode = afc_pkg::OP_TEST;
		rand_span(r.box_x_min, r.box_x_max);
		rand_span(r.box_y_min, r.box_y_max);
		rand_span(r.box_z_min, r.box_z_max);
		return r;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_req(input afc_pkg::in_item_t r, input bit known, input bit kv);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode      = r.opcode;
		plane_index = r.plane_index;
		coeff_index = r.coeff_index;
		coeff_value = r.coeff_value;
		box_x_min   = r.box_x_min;
		box_x_max   = r.box_x_max;
		box_y_min   = r.box_y_min;
		box_y_max   = r.box_y_max;
		box_z_min   = r.box_z_min;
		box_z_max   = r.box_z_max;
		push        = 1'b1;
		do @(posedge clk); while (full);
		if (r.opcode == afc_pkg::OP_TEST)
			visible_due.push_back(known ? kv : box_visible(r));
		else
			store_coeff(r);
		@(negedge clk);
	endtask

	// loads give no result, so allow the pipeline to empty after the last one
	task automatic drain();
		push = 1'b0;
		while (visible_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_tolerance(input logic [afc_pkg::TOL_W-1:0] v);
		tolerance_we   = 1'b1;
		tolerance_data = v;
		@(negedge clk);
		tolerance_we = 1'b0;
		tol_model    = v;
	endtask

	initial begin : result_side
		int gap;
		bit want;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				pop = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rx = 1'b0;
			end
			gap = $urandom_range(0, rx_max_gap);
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			if (visible_due.size() == 0) begin
				$display("%0t: stray result, visible=%0b with no test outstanding",
					$time, visible);
				n_err++;
			end else begin
				want = visible_due.pop_front();
				if (visible !== want) begin
					$display("%0t: visible mismatch, expected %0b, got %0b",
						$time, want, visible);
					n_err++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : request_side
		dir_row_t dir_tab [$];
		logic [afc_pkg::TOL_W-1:0] tol_set [N_PHASES];
		arst_n         = 1'b0;
		push           = 1'b0;
		opcode         = afc_pkg::OP_LOAD;
		plane_index    = '0;
		coeff_index    = '0;
		coeff_value    = '0;
		box_x_min      = '0;
		box_x_max      = '0;
		box_y_min      = '0;
		box_y_max      = '0;
		box_z_min      = '0;
		box_z_max      = '0;
		tolerance_we   = 1'b0;
		tolerance_data = '0;
		tx_max_gap     = 18;
		rx_max_gap     = 18;
		hold_rx        = 1'b0;
		n_err          = 0;
		idle_cycles    = 0;
		tol_model      = '0;
		foreach (plane_mem[i])
			plane_mem[i] = '0;

		// empty plane store never culls, whatever the box
		dir_tab.push_back('{mk_test(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX), 1'b1, 1'b1});
		dir_tab.push_back('{mk_test(VMAX, VMIN, VMAX, VMIN, VMAX, VMIN), 1'b1, 1'b1});
		// left plane x >= 0
		dir_tab.push_back('{mk_load(PL_LEFT, afc_pkg::CI_NX, ONE), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(-2*ONE, -ONE, 0, ONE, 0, ONE), 1'b1, 1'b0});
		dir_tab.push_back('{mk_test(-ONE, ONE, 0, ONE, 0, ONE), 1'b1, 1'b1});
		dir_tab.push_back('{mk_test(-ONE, 0, 0, ONE, 0, ONE), 1'b1, 1'b1});
		dir_tab.push_back('{mk_test(-ONE, -2*ONE, 0, ONE, 0, ONE), 1'b1, 1'b0});
		// right plane x <= 10
		dir_tab.push_back('{mk_load(PL_RIGHT, afc_pkg::CI_NX, -ONE), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_RIGHT, afc_pkg::CI_D, 10*ONE), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(11*ONE, 12*ONE, 0, ONE, 0, ONE), 1'b1, 1'b0});
		dir_tab.push_back('{mk_test(9*ONE, 10*ONE, 0, ONE, 0, ONE), 1'b1, 1'b1});
		// extreme coefficients against extreme bounds
		dir_tab.push_back('{mk_load(PL_TOP, afc_pkg::CI_NY, VMAX), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_TOP, afc_pkg::CI_D, VMIN), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(0, ONE, VMIN, VMAX, 0, ONE), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(0, ONE, VMAX, VMAX, 0, ONE), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_BOTTOM, afc_pkg::CI_NZ, VMIN), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_BOTTOM, afc_pkg::CI_D, VMAX), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(0, ONE, VMAX, VMAX, VMIN, VMAX), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(0, ONE, VMAX, VMAX, VMAX, VMAX), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_TOP, afc_pkg::CI_NY, 0), 1'b0, 1'b0});
		dir_tab.push_back('{mk_load(PL_TOP, afc_pkg::CI_D, 0), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(VMIN, VMIN, VMIN, VMAX, VMIN, VMAX), 1'b0, 1'b0});
		dir_tab.push_back('{mk_test(VMIN, VMAX, VMIN, VMAX, VMIN, VMAX), 1'b0, 1'b0});

		tol_set[0] = 16'hffff;
		tol_set[1] = 16'h0000;
		tol_set[2] = 16'h0001;
		tol_set[3] = 16'($urandom_range(2, 65534));
		tol_set[4] = 16'h8000;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_req(dir_tab[i].req, dir_tab[i].known, dir_tab[i].vis);
		drain();

		for (int ph = 0; ph < N_PHASES; ph++) begin
			set_tolerance(tol_set[ph]);
			case (ph)
				1: begin
					tx_max_gap = 0;
					rx_max_gap = 0;
				end
				2: begin
					// back-to-back requests into a stalled result side
					tx_max_gap = 0;
					rx_max_gap = 18;
					hold_rx    = 1'b1;
				end
				3: begin
					tx_max_gap = 18;
					rx_max_gap = 0;
				end
				default: begin
					tx_max_gap = 18;
					rx_max_gap = 18;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_req(rand_req(), 1'b0, 1'b0);
			drain();
		end

		if (n_err == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* aabb_frustum_cull.f */
rtl/afc_pkg.sv
rtl/afc_fifo.sv
rtl/afc_front.sv
rtl/afc_back.sv
rtl/aabb_frustum_cull.sv
tb/sv/tb_aabb_frustum_cull.sv
